### hw/rtl/cc20_pkg.sv
// Shared types and constants for the ChaCha20 stream engine.
`timescale 1ns / 1ps
package cc20_pkg;

  localparam int unsigned NonceBytes = 8;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned CfgIdxW    = 3;

  typedef enum logic [2:0] {
    CFG_MODE  = 3'd0,
    CFG_KEY0  = 3'd1,
    CFG_KEY1  = 3'd2,
    CFG_KEY2  = 3'd3,
    CFG_KEY3  = 3'd4,
    CFG_NONCE = 3'd5
  } cfg_idx_e;

  // Job handed from front to back.
  typedef enum logic [1:0] {
    JOB_DATA   = 2'd0,  // xor one byte, last
    JOB_HDR    = 2'd1,  // emit nonce header then xor the byte
    JOB_NEWDEC = 2'd2   // fresh stream with gathered nonce, xor nothing
  } job_e;

  typedef struct packed {
    job_e        kind;
    logic [7:0]  data;
    logic [63:0] nonce;
  } job_t;

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

endpackage

### hw/rtl/chacha20_stream_with_nonce_header.sv
// Top level of the ChaCha20 byte-stream engine with nonce header.
// Usage:
//  - Config channel (cfg_valid/cfg_ready, cfg_index_i, cfg_data_i): index 0
//    mode (1 encrypt), 1..4 key words, 5 tx nonce. Always ready; write idle.
//  - Input words (in_valid/in_ready): data_byte_i, new_stream_i. The front
//    end classifies each word, gathers a decrypt nonce from the stream, and
//    queues jobs in a two-entry queue so it keeps accepting while the back
//    end works.
//  - Output words (out_valid/out_ready): out_byte_o, is_nonce_o, last_o,
//    held in an output register; a stalled receiver holds the back end.
// A data word passes through the job queue, the back end's byte register and
// the output register. Each byte takes the back end from idle to xor and back
// when keystream is ready; each 64-byte block also runs the core, the single
// shared quarter-round unit (80 steps plus launch and final add). An encrypt
// stream start emits 8 header words first, one per cycle while the receiver
// does not stall.
// Reset clears mode, keys, nonce, stream state and the queue; the block
// then has no open stream and drops data words until a new_stream word.
`timescale 1ns / 1ps
module chacha20_stream_with_nonce_header (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [cc20_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte_i,
  input  logic        new_stream_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte_o,
  output logic        is_nonce_o,
  output logic        last_o
);
  import cc20_pkg::*;

  logic         mode_q;
  logic [255:0] key_q;
  logic [63:0]  txn_q;
  logic         job_valid, job_ready;
  job_t         job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0; key_q <= '0; txn_q <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index_i)
        CFG_MODE:  mode_q <= cfg_data_i[0];
        CFG_KEY0:  key_q[63:0]    <= cfg_data_i;
        CFG_KEY1:  key_q[127:64]  <= cfg_data_i;
        CFG_KEY2:  key_q[191:128] <= cfg_data_i;
        CFG_KEY3:  key_q[255:192] <= cfg_data_i;
        CFG_NONCE: txn_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cc20_front u_front (
    .clk_i, .rst_ni, .mode_i(mode_q), .tx_nonce_i(txn_q),
    .in_valid, .in_ready, .data_byte_i, .new_stream_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  cc20_back u_back (
    .clk_i, .rst_ni, .key_i(key_q),
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .out_valid, .out_ready, .out_byte_o, .is_nonce_o, .last_o
  );
endmodule

### hw/rtl/cc20_front.sv
// Front end: classifies input words, gathers the decrypt nonce, queues jobs.
`timescale 1ns / 1ps
module cc20_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             mode_i,
  input  logic [63:0]      tx_nonce_i,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_byte_i,
  input  logic             new_stream_i,
  output logic             job_valid_o,
  input  logic             job_ready_i,
  output cc20_pkg::job_t   job_o
);
  import cc20_pkg::*;

  // two-entry queue
  job_t        fifo_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic [1:0]  phase_q;       // 0 idle, 1 gather, 2 stream
  logic [2:0]  ncnt_q;
  logic [63:0] nonce_q;

  logic acc, push, pop;
  job_t nj;

  assign in_ready    = (cnt_q != 2'd2);
  assign acc         = in_valid && in_ready;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = fifo_q[rp_q];
  assign pop         = job_valid_o && job_ready_i;

  always_comb begin
    push      = 1'b0;
    nj.kind   = JOB_DATA;
    nj.data   = data_byte_i;
    nj.nonce  = tx_nonce_i;
    if (acc) begin
      if (new_stream_i && mode_i) begin
        push = 1'b1;
        nj.kind = JOB_HDR;
      end else if (!new_stream_i && phase_q == 2'd2) begin
        push = 1'b1;
      end else if (!new_stream_i && phase_q == 2'd1 && ncnt_q == 3'd7) begin
        push = 1'b1;
        nj.kind  = JOB_NEWDEC;
        nj.nonce = {data_byte_i, nonce_q[55:0]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= nj;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
      phase_q <= 2'd0; ncnt_q <= 3'd0; nonce_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
      if (acc) begin
        if (new_stream_i) begin
          phase_q <= mode_i ? 2'd2 : 2'd1;
          if (!mode_i) begin
            nonce_q <= {56'd0, data_byte_i};
            ncnt_q  <= 3'd1;
          end
        end else if (phase_q == 2'd1) begin
          nonce_q[{ncnt_q, 3'b000} +: 8] <= data_byte_i;
          ncnt_q <= ncnt_q + 3'd1;
          if (ncnt_q == 3'd7) phase_q <= 2'd2;
        end
      end
    end
  end
endmodule

### hw/rtl/cc20_core.sv
// ChaCha20 block function: one quarter-round step per cycle, 80 steps + add.
`timescale 1ns / 1ps
module cc20_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [255:0]  key_i,
  input  logic [63:0]   ctr_i,
  input  logic [63:0]   nonce_i,
  output logic          done_o,
  output logic [511:0]  ks_o
);
  import cc20_pkg::*;

  logic [31:0] x_q [16];
  logic [31:0] in_q [16];
  logic [6:0]  step_q;
  logic        busy_q;
  logic        done_q;
  logic [3:0]  ia, ib, ic, id;
  logic [31:0] a1, d1, c1, b1, a2, d2, c2, b2;
  logic [1:0]  lane;
  logic        diag;

  assign lane = step_q[1:0];
  assign diag = step_q[2];

  always_comb begin
    ia = {2'b00, lane};
    ib = diag ? {2'b01, lane + 2'd1} : {2'b01, lane};
    ic = diag ? {2'b10, lane + 2'd2} : {2'b10, lane};
    id = diag ? {2'b11, lane + 2'd3} : {2'b11, lane};
    a1 = x_q[ia] + x_q[ib];
    d1 = rotl(x_q[id] ^ a1, 16);
    c1 = x_q[ic] + d1;
    b1 = rotl(x_q[ib] ^ c1, 12);
    a2 = a1 + b1;
    d2 = rotl(d1 ^ a2, 8);
    c2 = c1 + d2;
    b2 = rotl(b1 ^ c2, 7);
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_q[0] <= Sigma0; in_q[1] <= Sigma1; in_q[2] <= Sigma2; in_q[3] <= Sigma3;
      x_q[0]  <= Sigma0; x_q[1]  <= Sigma1; x_q[2]  <= Sigma2; x_q[3]  <= Sigma3;
      for (int i = 0; i < 8; i++) begin
        in_q[4+i] <= key_i[32*i +: 32];
        x_q[4+i]  <= key_i[32*i +: 32];
      end
      in_q[12] <= ctr_i[31:0];    x_q[12] <= ctr_i[31:0];
      in_q[13] <= ctr_i[63:32];   x_q[13] <= ctr_i[63:32];
      in_q[14] <= nonce_i[31:0];  x_q[14] <= nonce_i[31:0];
      in_q[15] <= nonce_i[63:32]; x_q[15] <= nonce_i[63:32];
    end else if (busy_q) begin
      x_q[ia] <= a2; x_q[ib] <= b2; x_q[ic] <= c2; x_q[id] <= d2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; step_q <= '0; done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1; step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 7'd1;
        if (step_q == 7'd79) begin
          busy_q <= 1'b0; done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  always_comb begin
    for (int i = 0; i < 16; i++) ks_o[32*i +: 32] = x_q[i] + in_q[i];
  end
endmodule

### hw/rtl/cc20_back.sv
// Back end: keystream block buffer, header emission and byte xor.
`timescale 1ns / 1ps
module cc20_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [255:0]    key_i,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  cc20_pkg::job_t  job_i,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte_o,
  output logic            is_nonce_o,
  output logic            last_o
);
  import cc20_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_HDR  = 5'b00010,
    ST_GEN  = 5'b00100,
    ST_WAIT = 5'b01000,
    ST_XOR  = 5'b10000
  } st_e;

  st_e         st_q;
  logic [63:0] nonce_q, ctr_q;
  logic [5:0]  off_q;
  logic        ksv_q;
  logic [7:0]  data_q;
  logic [2:0]  hcnt_q;
  logic [511:0] ks_q;
  logic        ov_q;
  logic [7:0]  ob_q;
  logic        on_q, ol_q;
  logic        start, done;
  logic [511:0] ks;
  logic        slot;
  logic        emit;

  assign slot = !ov_q || out_ready;
  // a new output word is loaded this cycle
  assign emit = slot && (st_q == ST_HDR || st_q == ST_XOR);
  assign job_ready_o = (st_q == ST_IDLE);
  assign start = (st_q == ST_GEN);
  assign out_valid = ov_q;
  assign out_byte_o = ob_q;
  assign is_nonce_o = on_q;
  assign last_o = ol_q;

  cc20_core u_core (
    .clk_i, .rst_ni, .start_i(start), .key_i, .ctr_i(ctr_q), .nonce_i(nonce_q),
    .done_o(done), .ks_o(ks)
  );

  always_ff @(posedge clk_i) begin
    if (done) ks_q <= ks;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; nonce_q <= '0; ctr_q <= '0; off_q <= '0; ksv_q <= 1'b0;
      data_q <= '0; hcnt_q <= '0; ov_q <= 1'b0; ob_q <= '0; on_q <= 1'b0;
      ol_q <= 1'b0;
    end else begin
      if (emit) ov_q <= 1'b1;
      else if (out_ready) ov_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            data_q <= job_i.data;
            case (job_i.kind)
              JOB_HDR: begin
                nonce_q <= job_i.nonce; ctr_q <= '0; off_q <= '0; ksv_q <= 1'b0;
                hcnt_q <= '0; st_q <= ST_HDR;
              end
              JOB_NEWDEC: begin
                nonce_q <= job_i.nonce; ctr_q <= '0; off_q <= '0; ksv_q <= 1'b0;
              end
              default: st_q <= ksv_q ? ST_XOR : ST_GEN;
            endcase
          end
        end
        ST_HDR: begin
          if (slot) begin
            ob_q <= nonce_q[{hcnt_q, 3'b000} +: 8];
            on_q <= 1'b1; ol_q <= 1'b0;
            hcnt_q <= hcnt_q + 3'd1;
            if (hcnt_q == 3'd7) st_q <= ST_GEN;
          end
        end
        ST_GEN: st_q <= ST_WAIT;
        ST_WAIT: begin
          if (done) begin
            ksv_q <= 1'b1; st_q <= ST_XOR;
          end
        end
        ST_XOR: begin
          if (slot) begin
            ob_q <= data_q ^ ks_q[{off_q, 3'b000} +: 8];
            on_q <= 1'b0; ol_q <= 1'b1;
            off_q <= off_q + 6'd1;
            if (off_q == 6'd63) begin
              ctr_q <= ctr_q + 64'd1; ksv_q <= 1'b0;
            end
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end
endmodule

### hw/rtl/cc20_checker.sv
// Port-level checker for the ChaCha20 stream engine, bound to the top level.
`timescale 1ns / 1ps
module cc20_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte_o,
  input logic       is_nonce_o,
  input logic       last_o,
  input logic       cfg_ready
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_o))
    else $error("output word dropped while stalled");
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(is_nonce_o && last_o))
    else $error("header word marked last");
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready)
    else $error("config port not ready");
endmodule

bind chacha20_stream_with_nonce_header cc20_checker u_chk (
  .clk_i, .rst_ni, .out_valid, .out_ready, .out_byte_o, .is_nonce_o, .last_o,
  .cfg_ready
);

### test/testbench.sv
// Self-checking testbench for the ChaCha20 byte-stream engine with nonce header.
`timescale 1ns / 1ps
module testbench;
  import cc20_pkg::*;

  typedef struct {
    logic [7:0] out_byte;
    logic       is_nonce;
    logic       last;
  } cipher_word_t;

  // Scoreboard: its own copy of the engine state predicts the output words.
  class cipher_scoreboard;
    logic        enc_mode;
    logic [63:0] key_words[4];
    logic [63:0] hdr_nonce;
    logic [1:0]  phase;
    logic [3:0]  nonce_cnt;
    logic [63:0] cur_nonce;
    logic [63:0] blk_cnt;
    logic [5:0]  offset;
    logic [7:0]  ks[64];
    logic        ks_ok;
    cipher_word_t pending[$];
    int          mismatches;
    int          checked;

    function void clear();
      enc_mode = 0; hdr_nonce = 0; phase = 0; nonce_cnt = 0;
      cur_nonce = 0; blk_cnt = 0; offset = 0; ks_ok = 0;
      foreach (key_words[i]) key_words[i] = 0;
      pending.delete();
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [63:0] val);
      case (idx)
        CFG_MODE:  enc_mode = val[0];
        CFG_KEY0:  key_words[0] = val;
        CFG_KEY1:  key_words[1] = val;
        CFG_KEY2:  key_words[2] = val;
        CFG_KEY3:  key_words[3] = val;
        CFG_NONCE: hdr_nonce = val;
        default: ;
      endcase
    endfunction

    function void qr(ref logic [31:0] s[16], input int a, int b, int c, int d);
      s[a] += s[b]; s[d] ^= s[a]; s[d] = {s[d][15:0], s[d][31:16]};
      s[c] += s[d]; s[b] ^= s[c]; s[b] = {s[b][19:0], s[b][31:20]};
      s[a] += s[b]; s[d] ^= s[a]; s[d] = {s[d][23:0], s[d][31:24]};
      s[c] += s[d]; s[b] ^= s[c]; s[b] = {s[b][24:0], s[b][31:25]};
    endfunction

    function void refill_keystream();
      logic [31:0] init[16];
      logic [31:0] s[16];
      logic [31:0] w;
      init[0] = Sigma0; init[1] = Sigma1; init[2] = Sigma2; init[3] = Sigma3;
      for (int i = 0; i < 4; i++) begin
        init[4 + 2 * i] = key_words[i][31:0];
        init[5 + 2 * i] = key_words[i][63:32];
      end
      init[12] = blk_cnt[31:0];   init[13] = blk_cnt[63:32];
      init[14] = cur_nonce[31:0]; init[15] = cur_nonce[63:32];
      s = init;
      for (int r = 0; r < 10; r++) begin
        qr(s, 0, 4, 8, 12); qr(s, 1, 5, 9, 13); qr(s, 2, 6, 10, 14); qr(s, 3, 7, 11, 15);
        qr(s, 0, 5, 10, 15); qr(s, 1, 6, 11, 12); qr(s, 2, 7, 8, 13); qr(s, 3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) begin
        w = s[i] + init[i];
        for (int j = 0; j < 4; j++) ks[4 * i + j] = w[8 * j +: 8];
      end
      ks_ok = 1;
    endfunction

    function logic [7:0] xor_keystream(logic [7:0] b);
      logic [7:0] r;
      if (!ks_ok) refill_keystream();
      r = b ^ ks[offset];
      offset = offset + 6'd1;
      if (offset == 0) begin
        blk_cnt = blk_cnt + 64'd1;  // wraps at 2^64
        ks_ok = 0;
      end
      return r;
    endfunction

    function void push(logic [7:0] b, logic n, logic l);
      cipher_word_t e;
      e.out_byte = b; e.is_nonce = n; e.last = l;
      pending.push_back(e);
    endfunction

    function void note_input(logic [7:0] b, logic fresh);
      if (fresh) begin
        blk_cnt = 0; offset = 0; ks_ok = 0; nonce_cnt = 0;
        if (enc_mode) begin
          cur_nonce = hdr_nonce;
          phase = 2'd2;
          for (int k = 0; k < NonceBytes; k++) push(cur_nonce[8 * k +: 8], 1'b1, 1'b0);
          push(xor_keystream(b), 1'b0, 1'b1);
          return;
        end
        cur_nonce = 0;
        phase = 2'd1;
      end
      if (phase == 2'd1) begin
        cur_nonce[8 * nonce_cnt[2:0] +: 8] = b;
        nonce_cnt = nonce_cnt + 4'd1;
        if (nonce_cnt >= NonceBytes) phase = 2'd2;
      end else if (phase == 2'd2) begin
        push(xor_keystream(b), 1'b0, 1'b1);
      end
    endfunction

    function void check_output(cipher_word_t got);
      cipher_word_t exp;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected word byte=%h nonce=%b last=%b",
                   got.out_byte, got.is_nonce, got.last);
        return;
      end
      exp = pending.pop_front();
      if (got.out_byte !== exp.out_byte || got.is_nonce !== exp.is_nonce ||
          got.last !== exp.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: word %0d exp byte=%h nonce=%b last=%b, got byte=%h nonce=%b last=%b",
                   checked, exp.out_byte, exp.is_nonce, exp.last,
                   got.out_byte, got.is_nonce, got.last);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte_i;
  logic        new_stream_i;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte_o;
  logic        is_nonce_o;
  logic        last_o;

  chacha20_stream_with_nonce_header i_dut (.*);

  // 12 ns clock
  initial clk_i = 0;
  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  cipher_scoreboard sb;
  int  idle_cycles;
  int  bytes_sent;
  int  streams_started;
  int  enc_streams;
  int  dec_streams;
  bit  stall_long;   // receiver hold-off request
  bit  failed;

  localparam int IdleLimit = 20000;

  // Receiver: stalls on its own pattern; long hold-off when asked.
  initial begin
    int phase_len;
    int mode_sel;
    out_ready = 0;
    @(posedge rst_ni);
    forever begin
      if (stall_long) begin
        @(negedge clk_i) out_ready <= 0;
        repeat (400) @(negedge clk_i);
        stall_long = 0;
      end
      phase_len = $urandom_range(1, 40);
      mode_sel = $urandom_range(0, 3);
      repeat (phase_len) begin
        @(negedge clk_i);
        case (mode_sel)
          0: out_ready <= 1;                           // no stall stretch
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 1) != 0);
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Output monitor
  always @(posedge clk_i) begin
    cipher_word_t got;
    if (rst_ni && out_valid && out_ready) begin
      got.out_byte = out_byte_o;
      got.is_nonce = is_nonce_o;
      got.last = last_o;
      sb.check_output(got);
    end
  end

  // Watchdog: cycles in which nothing moves on either channel
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_ni ||
        (sb != null && sb.pending.size() == 0 && !in_valid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_valid <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk_i) cfg_valid <= 0;
  endtask

  // One input word; valid stays up across back-to-back words.
  task automatic send_byte(logic [7:0] b, logic fresh);
    data_byte_i <= b;
    new_stream_i <= fresh;
    in_valid <= 1;
    do @(posedge clk_i); while (!in_ready);
    sb.note_input(b, fresh);
    bytes_sent++;
    if (fresh) streams_started++;
    @(negedge clk_i);
  endtask

  task automatic pause_sender();
    in_valid <= 0;
    repeat ($urandom_range(1, 12)) @(negedge clk_i);
  endtask

  // Wait for all output and for the core to settle before a register write.
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic set_regs(logic m, logic [63:0] k0, logic [63:0] k1,
                          logic [63:0] k2, logic [63:0] k3, logic [63:0] n);
    write_reg(CFG_MODE, {63'd0, m});
    write_reg(CFG_KEY0, k0);
    write_reg(CFG_KEY1, k1);
    write_reg(CFG_KEY2, k2);
    write_reg(CFG_KEY3, k3);
    write_reg(CFG_NONCE, n);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random stream: start, optional nonce bytes, random-length body, with bursts.
  task automatic random_stream(int body_max);
    int len;
    if (sb.enc_mode) enc_streams++; else dec_streams++;
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    len = $urandom_range(0, body_max) + (sb.enc_mode ? 0 : 7);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 5) == 0) pause_sender();
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 60) == 0);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    failed = 0;
    bytes_sent = 0;
    streams_started = 0;
    enc_streams = 0;
    dec_streams = 0;
    stall_long = 0;
    rst_ni = 0;
    cfg_valid = 0;
    cfg_index_i = CFG_MODE;
    cfg_data_i = 0;
    in_valid = 0;
    data_byte_i = 0;
    new_stream_i = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1;
    @(negedge clk_i);

    // Directed: bytes with no open stream are dropped.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // Decrypt with all-zero key: nonce gathered from the stream.
    send_byte(8'h11, 1'b1);
    for (int i = 0; i < 7; i++) send_byte(8'hA0 + 8'(i), 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // Restart during nonce gathering.
    send_byte(8'h55, 1'b1);
    send_byte(8'h66, 1'b0);
    send_byte(8'h77, 1'b1);
    for (int i = 0; i < 8; i++) send_byte(8'hFF, 1'b0);
    drain();

    // Encrypt with all-ones key and nonce: header, then data.
    set_regs(1'b1, '1, '1, '1, '1, '1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    // Mode change inside a stream takes effect only at the next start.
    drain();
    write_reg(CFG_MODE, 64'd0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);   // now decrypt
    drain();

    // Key change inside a stream: crosses two block boundaries.
    set_regs(1'b1, 64'h0706050403020100, 64'h0F0E0D0C0B0A0908,
             64'h1716151413121110, 64'h1F1E1D1C1B1A1918, 64'h0000004A00000000);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    for (int i = 0; i < 70; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    drain();
    write_reg(CFG_KEY2, rand64());
    for (int i = 0; i < 70; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    drain();

    // Random phases with several settings; one long receiver hold-off.
    for (int ph = 0; ph < 6; ph++) begin
      set_regs(1'(ph % 2), rand64(), rand64(), rand64(), rand64(), rand64());
      if (ph == 2) stall_long = 1;
      while (bytes_sent < 150 + (ph + 1) * 45) random_stream(ph == 5 ? 140 : 40);
      drain();
    end

    if (sb.mismatches != 0 || sb.pending.size() != 0) failed = 1;
    if (sb.pending.size() != 0)
      $display("ERROR: %0d expected words never arrived", sb.pending.size());
    $display("Covered %0d input words in %0d streams (%0d encrypt, %0d decrypt random)",
             bytes_sent, streams_started, enc_streams, dec_streams);
    $display("Checked %0d output words, %0d mismatches", sb.checked, sb.mismatches);
    if (!failed)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
